[src/aefp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aefp_pkg: shared types and constants of the antenna element field pattern
// Fixed-point formats, reciprocal constants for the constant dividers and the
// field factor table, built at elaboration.
// ----------------------------------------------------------------------------
package aefp_pkg;

  // number formats
  localparam int ANGLE_FRAC_BITS   = 13;
  localparam int GAIN_FRAC_BITS    = 14;
  localparam int EXP_TABLE_ENTRIES = 64;

  localparam int ANG_W  = 15;   // vertical angle, wrapped azimuth magnitude
  localparam int HANG_W = 16;   // raw azimuth
  localparam int GAIN_W = 14;
  localparam int FF_W   = 15;
  localparam int T_W    = 18;   // azimuth plus pi, signed

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IS_USER_SIDE = 1'b0,
    CFG_MOUNT_KIND   = 1'b1
  } aefp_cfg_idx_t;

  // pi in angle units, rounded half up from Q30
  localparam logic [63:0] PI_Q30   = 64'd3373259426;
  localparam logic [63:0] PI_UNITS =
    (PI_Q30 + (64'd1 << (29 - ANGLE_FRAC_BITS))) >> (30 - ANGLE_FRAC_BITS);
  localparam logic [ANG_W-1:0]      PI_ANG   = ANG_W'(PI_UNITS);
  localparam logic signed [T_W-1:0] PI_S     = T_W'(PI_UNITS);
  localparam logic signed [T_W-1:0] TWO_PI_S = T_W'(64'd2 * PI_UNITS);

  // radians to 1/256 degree
  localparam int RAD_W     = 30;
  localparam int PROD_W    = ANG_W + RAD_W;
  localparam int DEG_SHIFT = 16 + ANGLE_FRAC_BITS;
  localparam int DEG_W     = 16;
  localparam logic [RAD_W-1:0]  RAD2DEG_C  = RAD_W'(64'd961263669);
  localparam logic [PROD_W:0]   DEG_HALF   = (PROD_W+1)'(64'd1 << (DEG_SHIFT - 1));
  localparam logic [DEG_W-1:0]  NINETY_DEG = DEG_W'(23040);

  // quadratic attenuation: den = 256 hpbw^2, split as 2^sh times the divider constant
  localparam int SQ_W      = 2 * DEG_W;
  localparam int NUM_W     = SQ_W + 4;
  localparam int SH90      = 10;
  localparam int SH65      = 8;
  localparam logic [NUM_W-1:0] HALF_DEN_90 = NUM_W'(64'd256 * 64'd90 * 64'd90 / 64'd2);
  localparam logic [NUM_W-1:0] HALF_DEN_65 = NUM_W'(64'd256 * 64'd65 * 64'd65 / 64'd2);

  localparam int ATT_X_W   = 26;
  localparam int ATT_D_W   = 13;
  localparam int ATT_M_W   = 30;
  localparam int ATT_Q_W   = 15;
  localparam int ATT_SHIFT = 40;
  localparam logic [ATT_D_W-1:0] DIV90_C   = ATT_D_W'((64'd256 * 64'd90 * 64'd90) >> SH90);
  localparam logic [ATT_D_W-1:0] DIV65_C   = ATT_D_W'((64'd256 * 64'd65 * 64'd65) >> SH65);
  localparam logic [ATT_M_W-1:0] RECIP90_C =
    ATT_M_W'((64'd1 << ATT_SHIFT) / ((64'd256 * 64'd90 * 64'd90) >> SH90));
  localparam logic [ATT_M_W-1:0] RECIP65_C =
    ATT_M_W'((64'd1 << ATT_SHIFT) / ((64'd256 * 64'd65 * 64'd65) >> SH65));

  // attenuation and gain in 1/256 dB
  localparam int ATT_W     = 13;
  localparam int ATT_SUM_W = ATT_W + 1;
  localparam logic [ATT_W-1:0]         ATT_MAX_C = ATT_W'(6400);
  localparam logic signed [GAIN_W-1:0] GMAX_C    = GAIN_W'(1280);
  localparam logic signed [GAIN_W-1:0] GMIN_C    = GAIN_W'(1280 - 6400);

  // table position: p = att * entries, split by 6400
  localparam int P_W       = $clog2(6400 * EXP_TABLE_ENTRIES + 1);
  localparam int IDX_W     = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int FR_W      = 13;
  localparam int IDX_M_W   = 20;
  localparam int IDX_SHIFT = 32;
  localparam logic [IDX_M_W-1:0] RECIP_IDX_C = IDX_M_W'((64'd1 << IDX_SHIFT) / 64'd6400);

  // interpolation: round(diff * fr / 6400)
  localparam int IP_X_W  = FF_W + FR_W;
  localparam int IP_M_W  = 32;
  localparam int IP_SHIFT = 44;
  localparam logic [IP_M_W-1:0] RECIP_IP_C = IP_M_W'((64'd1 << IP_SHIFT) / 64'd6400);
  localparam logic [IP_X_W-1:0] IP_HALF_C  = IP_X_W'(3200);

  // pipeline depth
  localparam int FRONT_LAT  = 6;
  localparam int DIV_LAT    = 3;
  localparam int INTERP_LAT = 2;
  localparam int PIPE_LAT   = FRONT_LAT + 3 * DIV_LAT + INTERP_LAT + 2;

  // field factor table
  localparam int FACTOR_BITS = 13;
  localparam logic [63:0] G5_Q30          = 64'd1909412977;
  localparam logic [63:0] STEP_FACTOR_Q30 = 64'd1073259045;

  typedef logic [FF_W-1:0] field_tab_t [0:EXP_TABLE_ENTRIES];

  function automatic logic [63:0] q30_mul(input logic [63:0] x, input logic [63:0] y);
    return (x * y + (64'd1 << 29)) >> 30;
  endfunction

  function automatic field_tab_t build_field_tab();
    field_tab_t  tab;
    logic [63:0] fac [0:FACTOR_BITS-1];
    logic [63:0] a;
    logic [63:0] v;
    logic [63:0] q;
    fac[0] = STEP_FACTOR_Q30;
    for (int b = 1; b < FACTOR_BITS; b++) begin
      fac[b] = q30_mul(fac[b-1], fac[b-1]);
    end
    for (int k = 0; k <= EXP_TABLE_ENTRIES; k++) begin
      a = (64'(k) * 64'd6400) / 64'(EXP_TABLE_ENTRIES);
      v = G5_Q30;
      for (int b = 0; b < FACTOR_BITS; b++) begin
        if (a[b]) begin
          v = q30_mul(v, fac[b]);
        end
      end
      q = (v + (64'd1 << (29 - GAIN_FRAC_BITS))) >> (30 - GAIN_FRAC_BITS);
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      tab[k] = FF_W'(q);
    end
    return tab;
  endfunction

  localparam field_tab_t FIELD_TAB = build_field_tab();

  // transaction payloads
  typedef struct packed {
    logic [ANG_W-1:0]         vertical_angle;
    logic signed [HANG_W-1:0] horizontal_angle;
  } aefp_in_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_db;
    logic [FF_W-1:0]          field_factor;
    logic                     angle_out_of_range;
  } aefp_out_t;

  // front end to attenuation dividers
  typedef struct packed {
    logic               vld;
    logic [ATT_X_W-1:0] xv;
    logic [ATT_X_W-1:0] xh;
    logic               use65;
    logic               flag;
  } aefp_front_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain;
    logic                     flag;
  } aefp_idx_side_t;

  typedef struct packed {
    logic [FF_W-1:0]          base;
    logic                     down;
    logic signed [GAIN_W-1:0] gain;
    logic                     flag;
  } aefp_ff_side_t;

  typedef struct packed {
    logic              vld;
    logic [IP_X_W-1:0] num;
    aefp_ff_side_t     side;
  } aefp_interp_t;

endpackage

[src/antenna_element_field_pattern.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// antenna_element_field_pattern: 3GPP element gain and field factor
// Fixed-point element pattern per angle pair: gain in dB and linear field
// amplitude from an interpolated table.
// ----------------------------------------------------------------------------
// usage: one angle pair is taken per clock whenever start is high and busy is
// low; busy is registered: it is only high during reset and clears once reset
// ends. every transaction gives exactly one result, shown on out_data for a
// single cycle with out_valid high, in the same order as accepted. the results
// cannot be held off, so the receiver must take each one as it comes. the
// pipeline has six front-end stages (pi offset, wrap, degree multiply,
// boresight offset, square, scale), three constant dividers of three stages
// each (attenuation, table position, interpolation step), two table stages
// and two combine/output stages. the pattern select registers are sampled
// when a transaction is accepted and should only be written while no
// transaction is in flight
// ----------------------------------------------------------------------------
module antenna_element_field_pattern import aefp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  aefp_in_t              in_data,
  output logic                  out_valid,
  output aefp_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // control and configuration
  logic busy_r;
  logic is_user_r, is_user_nxt;
  logic mount_r, mount_nxt;
  logic accept;
  logic use65;

  // front end and attenuation dividers
  aefp_front_t         front;
  logic [ATT_D_W-1:0]  den_v;
  logic [ATT_M_W-1:0]  recip_v;
  logic                vld_att;
  logic                vld_att_h;
  logic [ATT_Q_W-1:0]  q_v, q_h;
  logic                use65_att;
  logic                flag_att;

  // combine stage
  logic [ATT_W-1:0]     att_v, att_h, att;
  logic [ATT_SUM_W-1:0] att_sum;
  logic                 vld_cmb_r;
  logic [P_W-1:0]       p_cmb_r;
  aefp_idx_side_t       side_cmb_r, side_cmb_nxt;

  // table position
  logic              vld_idx;
  logic [IDX_W-1:0]  idx;
  logic [FR_W-1:0]   fr;
  aefp_idx_side_t    side_idx;

  // interpolation
  aefp_interp_t      interp;
  logic              vld_step;
  logic [FF_W-1:0]   step;
  aefp_ff_side_t     side_step;

  // output register
  logic              out_vld_r;
  aefp_out_t         out_r, out_nxt;

  assign accept = start && !busy_r;
  assign use65  = !is_user_r && mount_r;

  // register writes, no read-back
  always_comb begin
    is_user_nxt = is_user_r;
    mount_nxt   = mount_r;
    if (cfg_we) begin
      unique case (aefp_cfg_idx_t'(cfg_index))
        CFG_IS_USER_SIDE: is_user_nxt = cfg_wdata[0];
        CFG_MOUNT_KIND:   mount_nxt   = cfg_wdata[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      is_user_r <= 1'b0;
      mount_r   <= 1'b0;
    end else begin
      busy_r    <= 1'b0;
      is_user_r <= is_user_nxt;
      mount_r   <= mount_nxt;
    end
  end

  // wrap, degrees, offsets, squares
  aefp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (accept),
    .in_item (in_data),
    .use65   (use65),
    .front_o (front)
  );

  // single sector uses the 65 degree beamwidth on the vertical cut
  assign den_v   = front.use65 ? DIV65_C   : DIV90_C;
  assign recip_v = front.use65 ? RECIP65_C : RECIP90_C;

  aefp_cdiv #(
    .X_W    (ATT_X_W),
    .D_W    (ATT_D_W),
    .M_W    (ATT_M_W),
    .Q_W    (ATT_Q_W),
    .SHIFT  (ATT_SHIFT),
    .SIDE_W (1)
  ) u_div_att_v (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (front.vld),
    .num     (front.xv),
    .den     (den_v),
    .recip   (recip_v),
    .side_i  (front.use65),
    .out_vld (vld_att),
    .quo     (q_v),
    .rem     (),
    .side_o  (use65_att)
  );

  aefp_cdiv #(
    .X_W    (ATT_X_W),
    .D_W    (ATT_D_W),
    .M_W    (ATT_M_W),
    .Q_W    (ATT_Q_W),
    .SHIFT  (ATT_SHIFT),
    .SIDE_W (1)
  ) u_div_att_h (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (front.vld),
    .num     (front.xh),
    .den     (DIV90_C),
    .recip   (RECIP90_C),
    .side_i  (front.flag),
    .out_vld (vld_att_h),
    .quo     (q_h),
    .rem     (),
    .side_o  (flag_att)
  );

  // clamp each cut at 25 dB, then the sum for the two-cut patterns
  always_comb begin
    att_v   = (q_v > ATT_Q_W'(ATT_MAX_C)) ? ATT_MAX_C : ATT_W'(q_v);
    att_h   = (q_h > ATT_Q_W'(ATT_MAX_C)) ? ATT_MAX_C : ATT_W'(q_h);
    att_sum = ATT_SUM_W'(att_v) + ATT_SUM_W'(att_h);
    if (use65_att) begin
      att = att_v;
    end else if (att_sum > ATT_SUM_W'(ATT_MAX_C)) begin
      att = ATT_MAX_C;
    end else begin
      att = ATT_W'(att_sum);
    end
    side_cmb_nxt.gain = GMAX_C - $signed({1'b0, att});
    side_cmb_nxt.flag = flag_att;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_cmb_r <= 1'b0;
    end else begin
      vld_cmb_r <= vld_att && vld_att_h;
    end
  end

  always_ff @(posedge clk) begin
    p_cmb_r    <= P_W'(att) * P_W'(EXP_TABLE_ENTRIES);
    side_cmb_r <= side_cmb_nxt;
  end

  // node index and fraction: p / 6400 and p mod 6400
  aefp_cdiv #(
    .X_W    (P_W),
    .D_W    (FR_W),
    .M_W    (IDX_M_W),
    .Q_W    (IDX_W),
    .SHIFT  (IDX_SHIFT),
    .SIDE_W ($bits(aefp_idx_side_t))
  ) u_div_idx (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld_cmb_r),
    .num     (p_cmb_r),
    .den     (FR_W'(ATT_MAX_C)),
    .recip   (RECIP_IDX_C),
    .side_i  (side_cmb_r),
    .out_vld (vld_idx),
    .quo     (idx),
    .rem     (fr),
    .side_o  (side_idx)
  );

  aefp_interp u_interp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld_idx),
    .idx      (idx),
    .fr       (fr),
    .side_i   (side_idx),
    .interp_o (interp)
  );

  // rounded interpolation step
  aefp_cdiv #(
    .X_W    (IP_X_W),
    .D_W    (FR_W),
    .M_W    (IP_M_W),
    .Q_W    (FF_W),
    .SHIFT  (IP_SHIFT),
    .SIDE_W ($bits(aefp_ff_side_t))
  ) u_div_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (interp.vld),
    .num     (interp.num),
    .den     (FR_W'(ATT_MAX_C)),
    .recip   (RECIP_IP_C),
    .side_i  (interp.side),
    .out_vld (vld_step),
    .quo     (step),
    .rem     (),
    .side_o  (side_step)
  );

  // move from the lower node toward the next one
  always_comb begin
    out_nxt.gain_db            = side_step.gain;
    out_nxt.angle_out_of_range = side_step.flag;
    if (side_step.down) begin
      out_nxt.field_factor = side_step.base - step;
    end else begin
      out_nxt.field_factor = side_step.base + step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_step;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // every accepted transaction comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##PIPE_LAT out_valid)
    else $error("result missing after accepted transaction");

  // no result without a matching transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, PIPE_LAT))
    else $error("result without accepted transaction");

  // gain stays within the pattern limits
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.gain_db >= GMIN_C) && (out_data.gain_db <= GMAX_C))
    else $error("gain out of range");

  // full attenuation maps onto the last table node
  a_floor_factor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.gain_db == GMIN_C) |->
      out_data.field_factor == FIELD_TAB[EXP_TABLE_ENTRIES])
    else $error("field factor at floor gain is not the last node");
`endif

endmodule

[src/aefp_cdiv.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aefp_cdiv: pipelined divide by a constant
// Reciprocal multiply, back-multiply and one correction step; three stages.
// ----------------------------------------------------------------------------
module aefp_cdiv #(
  parameter int X_W    = 26,
  parameter int D_W    = 13,
  parameter int M_W    = 30,
  parameter int Q_W    = 15,
  parameter int SHIFT  = 40,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [X_W-1:0]    num,
  input  logic [D_W-1:0]    den,
  input  logic [M_W-1:0]    recip,
  input  logic [SIDE_W-1:0] side_i,
  output logic              out_vld,
  output logic [Q_W-1:0]    quo,
  output logic [D_W-1:0]    rem,
  output logic [SIDE_W-1:0] side_o
);

  localparam int PW   = X_W + M_W;
  localparam int QD_W = Q_W + D_W;

  logic              vld_a_r, vld_b_r, vld_c_r;
  logic [PW-1:0]     prod_a_r;
  logic [X_W-1:0]    num_a_r, num_b_r;
  logic [D_W-1:0]    den_a_r, den_b_r;
  logic [SIDE_W-1:0] side_a_r, side_b_r, side_c_r;
  logic [Q_W-1:0]    q0_b_r, quo_c_r;
  logic [QD_W-1:0]   qd_b_r;
  logic [D_W-1:0]    rem_c_r;

  logic [PW-1:0]     prod_a_nxt;
  logic [Q_W-1:0]    q0_b_nxt;
  logic [QD_W-1:0]   qd_b_nxt;
  logic [X_W-1:0]    rem_raw;
  logic [Q_W-1:0]    quo_c_nxt;
  logic [D_W-1:0]    rem_c_nxt;

  assign prod_a_nxt = {{M_W{1'b0}}, num} * {{X_W{1'b0}}, recip};
  assign q0_b_nxt   = Q_W'(prod_a_r >> SHIFT);
  assign qd_b_nxt   = QD_W'(q0_b_nxt) * QD_W'(den_a_r);

  // estimate is exact or one low
  always_comb begin
    rem_raw = num_b_r - X_W'(qd_b_r);
    if (rem_raw >= X_W'(den_b_r)) begin
      quo_c_nxt = q0_b_r + 1'b1;
      rem_c_nxt = D_W'(rem_raw - X_W'(den_b_r));
    end else begin
      quo_c_nxt = q0_b_r;
      rem_c_nxt = D_W'(rem_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
    end else begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_a_r <= prod_a_nxt;
    num_a_r  <= num;
    den_a_r  <= den;
    side_a_r <= side_i;
    q0_b_r   <= q0_b_nxt;
    qd_b_r   <= qd_b_nxt;
    num_b_r  <= num_a_r;
    den_b_r  <= den_a_r;
    side_b_r <= side_a_r;
    quo_c_r  <= quo_c_nxt;
    rem_c_r  <= rem_c_nxt;
    side_c_r <= side_b_r;
  end

  assign out_vld = vld_c_r;
  assign quo     = quo_c_r;
  assign rem     = rem_c_r;
  assign side_o  = side_c_r;

endmodule

[src/aefp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aefp_front: angle front end
// Azimuth wrap, conversion to degrees, offsets, squares and scaled numerators
// for the attenuation dividers; six stages.
// ----------------------------------------------------------------------------
module aefp_front import aefp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  aefp_in_t    in_item,
  input  logic        use65,
  output aefp_front_t front_o
);

  logic [FRONT_LAT-1:0] vld_r;
  logic [FRONT_LAT-1:0] use_r;
  logic [FRONT_LAT-1:0] flag_r;

  // stage 1
  logic [ANG_W-1:0]        v1_r;
  logic signed [T_W-1:0]   t1_r;
  logic signed [T_W-1:0]   t1_nxt;
  // stage 2
  logic [ANG_W-1:0]        v2_r, hm2_r;
  logic signed [T_W-1:0]   wrap;
  logic [ANG_W-1:0]        hm2_nxt;
  // stage 3
  logic [PROD_W-1:0]       pv3_r, ph3_r;
  // stage 4
  logic [DEG_W-1:0]        dv4_r, dh4_r;
  logic [DEG_W-1:0]        degv, dv4_nxt, dh4_nxt;
  // stage 5
  logic [SQ_W-1:0]         sqv5_r, sqh5_r;
  // stage 6
  logic [NUM_W-1:0]        nv, nh;
  logic [ATT_X_W-1:0]      xv6_r, xh6_r, xv6_nxt;

  assign t1_nxt = T_W'(in_item.horizontal_angle) + PI_S;

  // fold into [0, 2pi), then magnitude of the offset from pi
  always_comb begin
    if (t1_r < 0) begin
      wrap = t1_r + TWO_PI_S;
    end else if (t1_r >= TWO_PI_S) begin
      wrap = t1_r - TWO_PI_S;
    end else begin
      wrap = t1_r;
    end
    if (wrap >= PI_S) begin
      hm2_nxt = ANG_W'(wrap - PI_S);
    end else begin
      hm2_nxt = ANG_W'(PI_S - wrap);
    end
  end

  always_comb begin
    degv    = DEG_W'(((PROD_W+1)'(pv3_r) + DEG_HALF) >> DEG_SHIFT);
    dh4_nxt = DEG_W'(((PROD_W+1)'(ph3_r) + DEG_HALF) >> DEG_SHIFT);
    dv4_nxt = (degv >= NINETY_DEG) ? (degv - NINETY_DEG) : (NINETY_DEG - degv);
  end

  always_comb begin
    nv = NUM_W'(sqv5_r) * NUM_W'(12) + (use_r[4] ? HALF_DEN_65 : HALF_DEN_90);
    nh = NUM_W'(sqh5_r) * NUM_W'(12) + HALF_DEN_90;
    xv6_nxt = use_r[4] ? ATT_X_W'(nv >> SH65) : ATT_X_W'(nv >> SH90);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[FRONT_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    use_r  <= {use_r[FRONT_LAT-2:0], use65};
    flag_r <= {flag_r[FRONT_LAT-2:0], (in_item.vertical_angle > PI_ANG)};
    v1_r   <= in_item.vertical_angle;
    t1_r   <= t1_nxt;
    v2_r   <= v1_r;
    hm2_r  <= hm2_nxt;
    pv3_r  <= PROD_W'(v2_r) * PROD_W'(RAD2DEG_C);
    ph3_r  <= PROD_W'(hm2_r) * PROD_W'(RAD2DEG_C);
    dv4_r  <= dv4_nxt;
    dh4_r  <= dh4_nxt;
    sqv5_r <= SQ_W'(dv4_r) * SQ_W'(dv4_r);
    sqh5_r <= SQ_W'(dh4_r) * SQ_W'(dh4_r);
    xv6_r  <= xv6_nxt;
    xh6_r  <= ATT_X_W'(nh >> SH90);
  end

  assign front_o.vld   = vld_r[FRONT_LAT-1];
  assign front_o.xv    = xv6_r;
  assign front_o.xh    = xh6_r;
  assign front_o.use65 = use_r[FRONT_LAT-1];
  assign front_o.flag  = flag_r[FRONT_LAT-1];

endmodule

[src/aefp_interp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aefp_interp: field factor table read and interpolation product
// Reads the two neighboring nodes and forms the rounded numerator of the
// step toward the next node; two stages.
// ----------------------------------------------------------------------------
module aefp_interp import aefp_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  input  logic [IDX_W-1:0] idx,
  input  logic [FR_W-1:0]  fr,
  input  aefp_idx_side_t side_i,
  output aefp_interp_t   interp_o
);

  logic                vld1_r, vld2_r;
  logic [FF_W-1:0]     base1_r, diff1_r;
  logic                down1_r;
  logic [FR_W-1:0]     fr1_r;
  aefp_idx_side_t      side1_r;
  logic [IP_X_W-1:0]   num2_r;
  aefp_ff_side_t       side2_r;

  logic [FF_W-1:0]     cur, nxt;
  logic [FF_W-1:0]     base1_nxt, diff1_nxt;
  logic                down1_nxt;

  // past the last node the factor is pinned to the last node
  always_comb begin
    cur = FIELD_TAB[idx];
    nxt = cur;
    base1_nxt = cur;
    diff1_nxt = '0;
    down1_nxt = 1'b1;
    if (idx >= IDX_W'(EXP_TABLE_ENTRIES)) begin
      base1_nxt = FIELD_TAB[EXP_TABLE_ENTRIES];
    end else begin
      nxt = FIELD_TAB[IDX_W'(idx + 1'b1)];
      if (nxt <= cur) begin
        down1_nxt = 1'b1;
        diff1_nxt = cur - nxt;
      end else begin
        down1_nxt = 1'b0;
        diff1_nxt = nxt - cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    base1_r      <= base1_nxt;
    diff1_r      <= diff1_nxt;
    down1_r      <= down1_nxt;
    fr1_r        <= fr;
    side1_r      <= side_i;
    num2_r       <= IP_X_W'(diff1_r) * IP_X_W'(fr1_r) + IP_HALF_C;
    side2_r.base <= base1_r;
    side2_r.down <= down1_r;
    side2_r.gain <= side1_r.gain;
    side2_r.flag <= side1_r.flag;
  end

  assign interp_o.vld  = vld2_r;
  assign interp_o.num  = num2_r;
  assign interp_o.side = side2_r;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the antenna element field pattern
// Drives zenith/azimuth pairs through every pattern selection, predicts gain,
// field factor and the zenith flag per transaction and checks each result in
// order, with random sender gaps and two back-to-back stretches at the end.
// ----------------------------------------------------------------------------
module tb_top;
  import aefp_pkg::*;

  // fixed-point constants of the element pattern
  localparam longint unsigned HALF_TURN_Q30  = 64'd3373259426;
  localparam longint unsigned RAD_TO_DEG_Q24 = 64'd961263669;
  localparam longint unsigned BOOST_5DB_Q30  = 64'd1909412977;
  localparam longint unsigned ATT_STEP_Q30   = 64'd1073259045;
  localparam int              ATT_BIT_COUNT  = 13;
  localparam longint unsigned FULL_ATT       = 64'd6400;   // 25 dB in 1/256 dB
  localparam longint          PEAK_GAIN      = 1280;       // 5 dB in 1/256 dB
  localparam longint unsigned BORESIGHT_DEG  = 64'd23040;  // 90 degrees, 1/256 deg
  localparam longint unsigned HPBW_WIDE      = 64'd90;
  localparam longint unsigned HPBW_SECTOR    = 64'd65;
  localparam int              DEGREE_SHIFT   = 16 + ANGLE_FRAC_BITS;
  localparam longint unsigned HALF_TURN      =
    (HALF_TURN_Q30 + (64'd1 << (29 - ANGLE_FRAC_BITS))) >> (30 - ANGLE_FRAC_BITS);
  localparam int              HALF_TURN_I    = int'(HALF_TURN);
  localparam int              QUARTER_TURN_I = HALF_TURN_I / 2;

  // register values
  localparam bit PATTERN_GNB  = 1'b0;
  localparam bit PATTERN_UE   = 1'b1;
  localparam bit MOUNT_WALL   = 1'b0;
  localparam bit MOUNT_SECTOR = 1'b1;

  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_PRINTS   = 40;

  typedef struct {
    aefp_in_t  ang;
    aefp_out_t want;
  } pattern_expect_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  aefp_in_t              in_data   = '0;
  logic                  out_valid;
  aefp_out_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_IS_USER_SIDE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state: shadow registers and the field factor table
  bit              ue_sel;
  bit              sector_sel;
  longint unsigned field_lut [0:EXP_TABLE_ENTRIES];
  pattern_expect_t pending_patterns [$];

  // run statistics
  int  mismatch_count = 0;
  int  pairs_sent     = 0;
  int  results_seen   = 0;
  int  flagged_seen   = 0;
  int  floor_seen     = 0;
  int  peak_seen      = 0;
  int  quiet_cycles   = 0;
  bit  idle_on        = 1'b1;

  antenna_element_field_pattern uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // prediction
  // ------------------------------------------------------------------------

  // q30 product, rounded half up
  function automatic longint unsigned mul_q30(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // table node k holds 10^(5/20) * 10^(-a_k/5120), built from per-bit factors
  function automatic void build_field_lut();
    longint unsigned step_pow [ATT_BIT_COUNT];
    longint unsigned node_att;
    longint unsigned acc;
    longint unsigned rounded;
    step_pow[0] = ATT_STEP_Q30;
    for (int b = 1; b < ATT_BIT_COUNT; b++) begin
      step_pow[b] = mul_q30(step_pow[b-1], step_pow[b-1]);
    end
    for (int k = 0; k <= EXP_TABLE_ENTRIES; k++) begin
      node_att = (longint'(k) * FULL_ATT) / EXP_TABLE_ENTRIES;
      acc = BOOST_5DB_Q30;
      for (int b = 0; b < ATT_BIT_COUNT; b++) begin
        if (node_att[b]) begin
          acc = mul_q30(acc, step_pow[b]);
        end
      end
      rounded = (acc + (64'd1 << (29 - GAIN_FRAC_BITS))) >> (30 - GAIN_FRAC_BITS);
      if (rounded > 64'd32767) begin
        rounded = 64'd32767;
      end
      field_lut[k] = rounded;
    end
  endfunction

  // radians (angle units) to 1/256 degree, rounded
  function automatic longint unsigned rad_to_deg256(longint unsigned mag);
    return (mag * RAD_TO_DEG_Q24 + (64'd1 << (DEGREE_SHIFT - 1))) >> DEGREE_SHIFT;
  endfunction

  // 12 (d/hpbw)^2 in 1/256 dB, rounded, capped at 25 dB
  function automatic longint unsigned quad_loss(longint unsigned d, longint unsigned bw);
    longint unsigned den;
    longint unsigned loss;
    den  = 64'd256 * bw * bw;
    loss = (64'd12 * d * d + den / 2) / den;
    return (loss > FULL_ATT) ? FULL_ATT : loss;
  endfunction

  function automatic aefp_out_t predict_pattern(aefp_in_t ang, bit ue, bit sector);
    longint          h;
    longint unsigned vmag;
    longint unsigned hmag;
    longint unsigned dv;
    longint unsigned dh;
    longint unsigned degv;
    longint unsigned att;
    longint unsigned pos;
    longint unsigned node;
    longint unsigned frac;
    longint unsigned cur;
    longint unsigned nxt;
    longint unsigned ff;
    longint          gain;
    aefp_out_t       res;
    vmag = ang.vertical_angle;
    h    = longint'($signed(ang.horizontal_angle));

    // azimuth wrap into [-pi, pi), any number of turns
    h = (h + longint'(HALF_TURN)) % (2 * longint'(HALF_TURN));
    if (h < 0) begin
      h += 2 * longint'(HALF_TURN);
    end
    h -= longint'(HALF_TURN);
    hmag = (h < 0) ? -h : h;

    degv = rad_to_deg256(vmag);
    dv   = (degv >= BORESIGHT_DEG) ? degv - BORESIGHT_DEG : BORESIGHT_DEG - degv;
    dh   = rad_to_deg256(hmag);

    // ue and wall mount use both planes, single sector only the vertical one
    if (ue || !sector) begin
      att = quad_loss(dv, HPBW_WIDE) + quad_loss(dh, HPBW_WIDE);
      if (att > FULL_ATT) begin
        att = FULL_ATT;
      end
    end else begin
      att = quad_loss(dv, HPBW_SECTOR);
    end
    gain = PEAK_GAIN - longint'(att);

    // table lookup with linear interpolation between nodes
    pos  = att * EXP_TABLE_ENTRIES;
    node = pos / FULL_ATT;
    frac = pos % FULL_ATT;
    if (node >= EXP_TABLE_ENTRIES) begin
      ff = field_lut[EXP_TABLE_ENTRIES];
    end else begin
      cur = field_lut[node];
      nxt = field_lut[node + 1];
      if (nxt <= cur) begin
        ff = cur - ((cur - nxt) * frac + FULL_ATT / 2) / FULL_ATT;
      end else begin
        ff = cur + ((nxt - cur) * frac + FULL_ATT / 2) / FULL_ATT;
      end
    end

    res.gain_db            = GAIN_W'(gain);
    res.field_factor       = FF_W'(ff);
    res.angle_out_of_range = (vmag > HALF_TURN);
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // checking
  // ------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // results are compared first, then the accepted transaction is predicted,
  // so a result and a new transaction on the same edge never interfere
  always @(posedge clk) begin : scoreboard
    pattern_expect_t head;
    pattern_expect_t fresh;
    if (!rst_n) begin
      ue_sel     = 1'b0;
      sector_sel = 1'b0;
    end else begin
      if (out_valid) begin
        if (pending_patterns.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending, gain %0d ff %0d",
                                    $signed(out_data.gain_db), out_data.field_factor));
        end else begin
          head = pending_patterns.pop_front();
          results_seen++;
          if (out_data.gain_db !== head.want.gain_db) begin
            report_mismatch($sformatf("gain_db v=%0d h=%0d got %0d want %0d",
                                      head.ang.vertical_angle,
                                      $signed(head.ang.horizontal_angle),
                                      $signed(out_data.gain_db),
                                      $signed(head.want.gain_db)));
          end
          if (out_data.field_factor !== head.want.field_factor) begin
            report_mismatch($sformatf("field_factor v=%0d h=%0d got %0d want %0d",
                                      head.ang.vertical_angle,
                                      $signed(head.ang.horizontal_angle),
                                      out_data.field_factor, head.want.field_factor));
          end
          if (out_data.angle_out_of_range !== head.want.angle_out_of_range) begin
            report_mismatch($sformatf("angle_out_of_range v=%0d got %0b want %0b",
                                      head.ang.vertical_angle,
                                      out_data.angle_out_of_range,
                                      head.want.angle_out_of_range));
          end
          if (head.want.angle_out_of_range) flagged_seen++;
          if ($signed(head.want.gain_db) == PEAK_GAIN - longint'(FULL_ATT)) floor_seen++;
          if ($signed(head.want.gain_db) == PEAK_GAIN) peak_seen++;
        end
      end

      // register writes land in the shadow copy
      if (cfg_we) begin
        case (cfg_index)
          CFG_IS_USER_SIDE: ue_sel = cfg_wdata[0];
          CFG_MOUNT_KIND:   sector_sel = cfg_wdata[0];
          default: ;
        endcase
      end

      // accepted transaction
      if (start && !busy) begin
        fresh.ang  = in_data;
        fresh.want = predict_pattern(in_data, ue_sel, sector_sel);
        pending_patterns.push_back(fresh);
      end
    end
  end

  // watchdog: too long without any transaction or result ends the run
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: %0d cycles without progress", quiet_cycles);
      $display("tb_top failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------------

  // one transaction, then at random a pause with start low when idling is on
  task automatic send_angles(aefp_in_t ang);
    int unsigned pause;
    start   <= 1'b1;
    in_data <= ang;
    @(posedge clk);
    while (busy) @(posedge clk);
    pairs_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      pause = $urandom_range(1, 16);
      start <= 1'b0;
      repeat (pause) @(posedge clk);
    end
  endtask

  // sender holds off until every pending result has come back
  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_patterns.size() != 0) @(posedge clk);
  endtask

  // both registers, only written while nothing is in flight
  task automatic set_pattern(bit ue, bit sector);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IS_USER_SIDE;
    cfg_wdata <= ue;
    @(posedge clk);
    cfg_index <= CFG_MOUNT_KIND;
    cfg_wdata <= sector;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic aefp_in_t random_angles();
    aefp_in_t ang;
    int       v;
    int       h;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        // valid zenith, azimuth already inside one turn
        v = int'($urandom_range(0, HALF_TURN_I));
        h = int'($urandom_range(0, 2 * HALF_TURN_I - 1)) - HALF_TURN_I;
      end
      6, 7: begin
        // raw full-range codes, zenith past pi and azimuth needing a wrap
        v = int'($urandom_range(0, 32767));
        h = int'($urandom_range(0, 65535)) - 32768;
      end
      8: begin
        // around the zenith limit and the azimuth wrap points
        v = HALF_TURN_I - 2 + int'($urandom_range(0, 4));
        h = ($urandom_range(0, 1) ? HALF_TURN_I : -HALF_TURN_I) - 3
            + int'($urandom_range(0, 6));
        if ($urandom_range(0, 1)) h += ($urandom_range(0, 1) ? 2 : -2) * HALF_TURN_I;
      end
      default: begin
        // near boresight: high gain, top end of the table
        v = QUARTER_TURN_I - 64 + int'($urandom_range(0, 128));
        h = int'($urandom_range(0, 512)) - 256;
      end
    endcase
    ang.vertical_angle   = ANG_W'(v);
    ang.horizontal_angle = HANG_W'(h);
    return ang;
  endfunction

  // corner pairs: zenith extremes, boresight, azimuth extremes and wraps
  task automatic test_directed(bit ue, bit sector, bit write_regs);
    int       vlist [12];
    int       hlist [12];
    aefp_in_t ang;
    vlist = '{0, HALF_TURN_I, HALF_TURN_I + 1, 32767, QUARTER_TURN_I, QUARTER_TURN_I,
              QUARTER_TURN_I, QUARTER_TURN_I, QUARTER_TURN_I, 16000, QUARTER_TURN_I, 0};
    hlist = '{0, 0, 0, 32767, 0, -32768, HALF_TURN_I, -HALF_TURN_I, HALF_TURN_I - 1,
              -HALF_TURN_I - 1, QUARTER_TURN_I, HALF_TURN_I};
    wait_for_results();
    if (write_regs) set_pattern(ue, sector);
    idle_on = 1'b1;
    for (int i = 0; i < 12; i++) begin
      ang.vertical_angle   = ANG_W'(vlist[i]);
      ang.horizontal_angle = HANG_W'(hlist[i]);
      send_angles(ang);
    end
  endtask

  // random pairs under one pattern, idling in stretches, one full drain midway
  task automatic test_random(bit ue, bit sector, int count);
    wait_for_results();
    set_pattern(ue, sector);
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (i == count / 2) wait_for_results();
      send_angles(random_angles());
    end
  endtask

  // last part: a transaction on every cycle, no sender gaps
  task automatic test_back_to_back(bit ue, bit sector, int count);
    wait_for_results();
    set_pattern(ue, sector);
    idle_on = 1'b0;
    for (int i = 0; i < count; i++) begin
      send_angles(random_angles());
    end
  endtask

  initial begin
    build_field_lut();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults first: base station, wall mount, no register write
    test_directed(PATTERN_GNB, MOUNT_WALL, 1'b0);
    test_random(PATTERN_GNB, MOUNT_WALL, 350);
    test_directed(PATTERN_GNB, MOUNT_SECTOR, 1'b1);
    test_random(PATTERN_GNB, MOUNT_SECTOR, 350);
    test_random(PATTERN_UE, MOUNT_WALL, 350);
    test_random(PATTERN_UE, MOUNT_SECTOR, 280);
    test_back_to_back(PATTERN_UE, MOUNT_SECTOR, 150);
    test_back_to_back(PATTERN_GNB, MOUNT_WALL, 150);

    // drain, then let the pipeline run out to catch stray results
    wait_for_results();
    repeat (PIPE_LAT + 8) @(posedge clk);
    if (pending_patterns.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_patterns.size()));
    end

    $display("covered %0d angle pairs over all four pattern selections, %0d results checked",
             pairs_sent, results_seen);
    $display("zenith flag raised %0d times, %0d at full attenuation, %0d at peak gain, %s",
             flagged_seen, floor_seen, peak_seen,
             $sformatf("%0d mismatches", mismatch_count));
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
